// ===== hdl/pgsd_pkg.sv =====
// Shared types, constants and index helpers for the periodic grid second-difference block.
package pgsd_pkg;

  localparam int GRID_SIZE = 64;
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int SAMPLE_W  = 16;
  localparam int SCALE_W   = 16;
  localparam int DIFF_W    = SAMPLE_W + 2;
  localparam int PROD_W    = DIFF_W + SCALE_W + 1;
  localparam int OUT_W     = 32;
  localparam int FRAC_SHIFT = 8;

  localparam logic [SCALE_W-1:0] INV_SPACING_SQ_RESET = SCALE_W'(25600);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] OUT_MIN = -(PROD_W'(64'sd1 <<< (OUT_W - 1)));

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;
  } pgsd_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] row_second_diff;
    logic signed [OUT_W-1:0] col_second_diff;
  } pgsd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_DIFF,
    ST_MUL,
    ST_RND
  } state_t;

  typedef enum logic [1:0] {
    RD_CENTER_EAST,
    RD_WEST_SOUTH,
    RD_NORTH
  } rd_phase_t;

  typedef struct packed {
    logic      load;
    logic      mem_we;
    rd_phase_t rd_phase;
    logic      cap_first;
    logic      cap_second;
    logic      diff_en;
    logic      mul_en;
    logic      out_query;
    logic      out_zero;
  } pgsd_cmd_t;

  function automatic logic [IDX_W-1:0] idx_reduce(input logic [IDX_W-1:0] i);
    if (int'(i) >= GRID_SIZE) begin
      return IDX_W'(int'(i) - GRID_SIZE);
    end
    return i;
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (int'(i) == GRID_SIZE - 1) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    if (i == '0) begin
      return IDX_W'(GRID_SIZE - 1);
    end
    return i - IDX_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c);
  endfunction

endpackage

// ===== hdl/pgsd_ctrl.sv =====
// Controller state machine that sequences writes and five-cell queries.
module pgsd_ctrl import pgsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      start_action,
  output logic      busy,
  output pgsd_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_phase = RD_CENTER_EAST;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (start_action == ACT_QUERY) ? ST_RD0 : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.mem_we   = 1'b1;
        cmd.out_zero = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_RD0: begin
        cmd.rd_phase = RD_CENTER_EAST;
        state_nxt    = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_phase  = RD_WEST_SOUTH;
        cmd.cap_first = 1'b1;
        state_nxt     = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_phase   = RD_NORTH;
        cmd.cap_second = 1'b1;
        state_nxt      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_RND;
      end
      ST_RND: begin
        cmd.out_query = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/pgsd_datapath.sv =====
// Datapath: grid memory, neighbor fetch, differences, scaling, rounding and result register.
module pgsd_datapath import pgsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pgsd_cmd_t          cmd,
  input  pgsd_in_t           in_item,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data,
  output logic               out_valid,
  output pgsd_out_t          out_item
);

  // Grid memory: one write port, two registered read ports.
  logic [SAMPLE_W-1:0] grid_mem [GRID_SIZE * GRID_SIZE];

  logic [SCALE_W-1:0]         inv_r;
  logic [IDX_W-1:0]           row_r, col_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0]        rd_a_r, rd_b_r;
  logic signed [SAMPLE_W-1:0] center_r, east_r, west_r, south_r;
  logic signed [DIFF_W-1:0]   drow_r, dcol_r;
  logic signed [PROD_W-1:0]   prow_r, pcol_r;
  logic                       out_valid_r;
  pgsd_out_t                  out_r;

  logic [ADDR_W-1:0]          addr_a, addr_b;
  logic signed [DIFF_W-1:0]   drow_nxt, dcol_nxt;
  logic signed [PROD_W-1:0]   scale_s;

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = (p + ROUND_BIAS) >>> FRAC_SHIFT;
    if (q > OUT_MAX) begin
      return OUT_MAX[OUT_W-1:0];
    end
    if (q < OUT_MIN) begin
      return OUT_MIN[OUT_W-1:0];
    end
    return q[OUT_W-1:0];
  endfunction

  always_comb begin
    addr_a = cell_addr(row_r, col_r);
    addr_b = cell_addr(row_r, idx_inc(col_r));
    unique case (cmd.rd_phase)
      RD_CENTER_EAST: begin
        addr_a = cell_addr(row_r, col_r);
        addr_b = cell_addr(row_r, idx_inc(col_r));
      end
      RD_WEST_SOUTH: begin
        addr_a = cell_addr(row_r, idx_dec(col_r));
        addr_b = cell_addr(idx_inc(row_r), col_r);
      end
      RD_NORTH: begin
        addr_a = cell_addr(idx_dec(row_r), col_r);
        addr_b = cell_addr(idx_dec(row_r), col_r);
      end
      default: begin
        addr_a = cell_addr(row_r, col_r);
        addr_b = cell_addr(row_r, col_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      grid_mem[cell_addr(row_r, col_r)] <= sample_r;
    end
    rd_a_r <= grid_mem[addr_a];
    rd_b_r <= grid_mem[addr_b];
  end

  // North sample arrives on read port A in the difference cycle.
  assign drow_nxt = DIFF_W'(east_r) + DIFF_W'(west_r) - (DIFF_W'(center_r) <<< 1);
  assign dcol_nxt = DIFF_W'(south_r) + DIFF_W'($signed(rd_a_r)) - (DIFF_W'(center_r) <<< 1);
  assign scale_s  = PROD_W'($signed({1'b0, inv_r}));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r    <= idx_reduce(in_item.row);
      col_r    <= idx_reduce(in_item.col);
      sample_r <= in_item.sample;
    end
    if (cmd.cap_first) begin
      center_r <= $signed(rd_a_r);
      east_r   <= $signed(rd_b_r);
    end
    if (cmd.cap_second) begin
      west_r  <= $signed(rd_a_r);
      south_r <= $signed(rd_b_r);
    end
    if (cmd.diff_en) begin
      drow_r <= drow_nxt;
      dcol_r <= dcol_nxt;
    end
    if (cmd.mul_en) begin
      prow_r <= PROD_W'(drow_r) * scale_s;
      pcol_r <= PROD_W'(dcol_r) * scale_s;
    end
    if (cmd.out_query) begin
      out_r.row_second_diff <= round_sat(prow_r);
      out_r.col_second_diff <= round_sat(pcol_r);
    end else if (cmd.out_zero) begin
      out_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r       <= INV_SPACING_SQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        inv_r <= cfg_data;
      end
      out_valid_r <= cmd.out_query | cmd.out_zero;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/periodic_grid_second_difference.sv =====
// Top level of the periodic grid second-difference block: controller plus datapath.
//
//   Channel   Ports                           Transaction completes when
//   --------  ------------------------------  -----------------------------------
//   input     start, busy, in_item            start high and busy low at clk edge
//   result    out_valid, out_item             out_valid high (one cycle strobe)
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
//
// A write captures the item on acceptance and writes the grid memory in the WRITE state.
// A query passes through three read states (RD0, RD1, RD2) that fetch the five cells
// through two read ports, then DIFF, MUL and RND for differences, multiply and rounding.
// Busy stays high until the result is registered, so the next item is accepted in the cycle
// its predecessor's result is on the ports. Synchronous reset idles the controller and loads
// an inverse squared spacing of 100.0; the grid is not cleared. The receiver cannot stall.
module periodic_grid_second_difference import pgsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pgsd_in_t           in_item,
  output logic               out_valid,
  output pgsd_out_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] cfg_data
);

  pgsd_cmd_t cmd;

  // Spacing always writable; software must write it only while idle (unchecked).
  assign cfg_ready = 1'b1;

  pgsd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .start_action (in_item.action),
    .busy         (busy),
    .cmd          (cmd)
  );

  pgsd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
